[src/tmf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmf_pkg
// Shared constants for the trimmed mean filter.
// ----------------------------------------------------------------------------
package tmf_pkg;

  localparam int CFG_W           = 6;
  localparam int CFG_RESET       = 10;
  localparam int MIN_SET         = 5;
  localparam int DROP_TOTAL      = 4;
  localparam int DEF_MAX_SAMPLES = 32;
  localparam int DEF_SAMPLE_BITS = 16;
  localparam int QUEUE_DEPTH     = 2;

endpackage

[src/tmf_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmf_front
// Accumulates one set: running sum, two highest and two lowest samples, count.
// On the last sample of a set it hands the final totals to the queue.
// ----------------------------------------------------------------------------
module tmf_front #(
  parameter int MAX_SAMPLES = tmf_pkg::DEF_MAX_SAMPLES,
  parameter int SAMPLE_BITS = tmf_pkg::DEF_SAMPLE_BITS,
  parameter int SUM_W       = SAMPLE_BITS + $clog2(MAX_SAMPLES + 1),
  parameter int KEPT_W      = $clog2(MAX_SAMPLES + 1)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  input  logic [SAMPLE_BITS-1:0]   sample_i,
  input  logic [tmf_pkg::CFG_W-1:0] cfg_count_i,
  output logic                     push_o,
  output logic [SUM_W-1:0]         sum_o,
  output logic [SAMPLE_BITS-1:0]   hi0_o,
  output logic [SAMPLE_BITS-1:0]   hi1_o,
  output logic [SAMPLE_BITS-1:0]   lo0_o,
  output logic [SAMPLE_BITS-1:0]   lo1_o,
  output logic [KEPT_W-1:0]        kept_o
);

  localparam int CMP_W = (KEPT_W > tmf_pkg::CFG_W) ? KEPT_W : tmf_pkg::CFG_W;

  logic [SUM_W-1:0]       sum_q, sum_d;
  logic [SAMPLE_BITS-1:0] hi0_q, hi0_d, hi1_q, hi1_d;
  logic [SAMPLE_BITS-1:0] lo0_q, lo0_d, lo1_q, lo1_d;
  logic [KEPT_W-1:0]      seen_q, seen_inc;
  logic [CMP_W-1:0]       cfg_ext, n_eff;
  logic                   set_end;

  always_comb begin
    sum_d = sum_q + SUM_W'(sample_i);
    hi0_d = hi0_q;
    hi1_d = hi1_q;
    lo0_d = lo0_q;
    lo1_d = lo1_q;
    if (sample_i > hi0_q) begin
      hi1_d = hi0_q;
      hi0_d = sample_i;
    end else if (sample_i > hi1_q) begin
      hi1_d = sample_i;
    end
    if (sample_i < lo0_q) begin
      lo1_d = lo0_q;
      lo0_d = sample_i;
    end else if (sample_i < lo1_q) begin
      lo1_d = sample_i;
    end
  end

  always_comb begin
    cfg_ext = CMP_W'(cfg_count_i);
    if (cfg_ext < CMP_W'(tmf_pkg::MIN_SET)) begin
      n_eff = CMP_W'(tmf_pkg::MIN_SET);
    end else if (cfg_ext > CMP_W'(MAX_SAMPLES)) begin
      n_eff = CMP_W'(MAX_SAMPLES);
    end else begin
      n_eff = cfg_ext;
    end
  end

  assign seen_inc = seen_q + KEPT_W'(1);
  assign set_end  = CMP_W'(seen_inc) >= n_eff;

  assign push_o = valid_i & set_end;
  assign sum_o  = sum_d;
  assign hi0_o  = hi0_d;
  assign hi1_o  = hi1_d;
  assign lo0_o  = lo0_d;
  assign lo1_o  = lo1_d;
  assign kept_o = seen_inc - KEPT_W'(tmf_pkg::DROP_TOTAL);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= '0;
      hi0_q  <= '0;
      hi1_q  <= '0;
      lo0_q  <= '1;
      lo1_q  <= '1;
      seen_q <= '0;
    end else if (valid_i) begin
      if (set_end) begin
        sum_q  <= '0;
        hi0_q  <= '0;
        hi1_q  <= '0;
        lo0_q  <= '1;
        lo1_q  <= '1;
        seen_q <= '0;
      end else begin
        sum_q  <= sum_d;
        hi0_q  <= hi0_d;
        hi1_q  <= hi1_d;
        lo0_q  <= lo0_d;
        lo1_q  <= lo1_d;
        seen_q <= seen_inc;
      end
    end
  end

endmodule

[src/tmf_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmf_queue
// Short register queue between the set tracker and the divider.
// ----------------------------------------------------------------------------
module tmf_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = tmf_pkg::QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_push, do_pop;

  assign full_o  = cnt_q == CNT_W'(DEPTH);
  assign valid_o = cnt_q != '0;
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

endmodule

[src/tmf_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmf_back
// Removes the four dropped samples from the sum, divides by the kept count
// one quotient bit per cycle and holds the mean in the output register.
// ----------------------------------------------------------------------------
module tmf_back #(
  parameter int SAMPLE_BITS = tmf_pkg::DEF_SAMPLE_BITS,
  parameter int SUM_W       = 21,
  parameter int KEPT_W      = 6
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   q_valid_i,
  input  logic [SUM_W-1:0]       sum_i,
  input  logic [SAMPLE_BITS-1:0] hi0_i,
  input  logic [SAMPLE_BITS-1:0] hi1_i,
  input  logic [SAMPLE_BITS-1:0] lo0_i,
  input  logic [SAMPLE_BITS-1:0] lo1_i,
  input  logic [KEPT_W-1:0]      kept_i,
  output logic                   q_pop_o,
  input  logic                   pop_i,
  output logic                   empty_o,
  output logic [SAMPLE_BITS-1:0] mean_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_TRIM = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;
  localparam int STEP_W = (SUM_W > 1) ? $clog2(SUM_W) : 1;

  logic [1:0]             state_q, state_d;
  logic [SUM_W-1:0]       num_q, num_d;
  logic [SAMPLE_BITS:0]   hs_q, hs_d, ls_q, ls_d;
  logic [KEPT_W-1:0]      div_q, div_d, rem_q, rem_d;
  logic [STEP_W-1:0]      step_q, step_d;
  logic                   out_valid_q, out_valid_d;
  logic [SAMPLE_BITS-1:0] mean_q, mean_d;
  logic [KEPT_W:0]        rem_sh, rem_sub;
  logic                   ge, out_free;

  assign rem_sh   = {rem_q, num_q[SUM_W-1]};
  assign ge       = rem_sh >= {1'b0, div_q};
  assign rem_sub  = rem_sh - {1'b0, div_q};
  assign out_free = ~out_valid_q | pop_i;
  assign q_pop_o  = (state_q == ST_IDLE) & q_valid_i;
  assign empty_o  = ~out_valid_q;
  assign mean_o   = mean_q;

  always_comb begin
    state_d     = state_q;
    num_d       = num_q;
    hs_d        = hs_q;
    ls_d        = ls_q;
    div_d       = div_q;
    rem_d       = rem_q;
    step_d      = step_q;
    mean_d      = mean_q;
    out_valid_d = out_valid_q & ~pop_i;
    case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          num_d   = sum_i;
          hs_d    = {1'b0, hi0_i} + {1'b0, hi1_i};
          ls_d    = {1'b0, lo0_i} + {1'b0, lo1_i};
          div_d   = kept_i;
          state_d = ST_TRIM;
        end
      end
      ST_TRIM: begin
        num_d   = num_q - SUM_W'(hs_q) - SUM_W'(ls_q);
        rem_d   = '0;
        step_d  = STEP_W'(SUM_W - 1);
        state_d = ST_DIV;
      end
      ST_DIV: begin
        rem_d  = ge ? rem_sub[KEPT_W-1:0] : rem_sh[KEPT_W-1:0];
        num_d  = {num_q[SUM_W-2:0], ge};
        step_d = step_q - STEP_W'(1);
        if (step_q == '0) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          mean_d      = num_q[SAMPLE_BITS-1:0];
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q  <= num_d;
    hs_q   <= hs_d;
    ls_q   <= ls_d;
    div_q  <= div_d;
    rem_q  <= rem_d;
    step_q <= step_d;
    mean_q <= mean_d;
  end

endmodule

[src/trimmed_mean_filter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trimmed_mean_filter
// Truncated mean of each set of samples without its two highest and two
// lowest samples.
// ----------------------------------------------------------------------------
// Samples are taken one per cycle while full is low. The set size comes from
// the count register (clamped to 5..MAX_SAMPLES); a set ends on its last
// sample, and one mean per set appears on the result side. A restoring divider
// forms the mean one quotient bit per cycle; each set passes the back end's
// idle, trim, divide and done states and waits in done until the output
// register is popped. A two-entry queue of finished sets sits between the
// sample tracker and the divider; full rises while it holds two sets, which
// only happens with sets shorter than the divider time or a stalled reader.
// ----------------------------------------------------------------------------
module trimmed_mean_filter #(
  parameter int MAX_SAMPLES = tmf_pkg::DEF_MAX_SAMPLES,
  parameter int SAMPLE_BITS = tmf_pkg::DEF_SAMPLE_BITS
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [tmf_pkg::CFG_W-1:0] cfg_wdata_i,
  input  logic                      push,
  output logic                      full,
  input  logic [SAMPLE_BITS-1:0]    sample_i,
  output logic                      empty,
  input  logic                      pop,
  output logic [SAMPLE_BITS-1:0]    trimmed_mean_o
);

  localparam int KEPT_W  = $clog2(MAX_SAMPLES + 1);
  localparam int SUM_W   = SAMPLE_BITS + KEPT_W;
  localparam int ENTRY_W = SUM_W + 4 * SAMPLE_BITS + KEPT_W;

  logic [tmf_pkg::CFG_W-1:0] count_q;
  logic                      accept, f_push, q_full, q_valid, q_pop;
  logic [SUM_W-1:0]          f_sum, b_sum;
  logic [SAMPLE_BITS-1:0]    f_hi0, f_hi1, f_lo0, f_lo1;
  logic [SAMPLE_BITS-1:0]    b_hi0, b_hi1, b_lo0, b_lo1;
  logic [KEPT_W-1:0]         f_kept, b_kept;
  logic [ENTRY_W-1:0]        q_wdata, q_rdata;

  assign full   = q_full;
  assign accept = push & ~q_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= tmf_pkg::CFG_W'(tmf_pkg::CFG_RESET);
    end else if (cfg_we_i) begin
      count_q <= cfg_wdata_i;
    end
  end

  tmf_front #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .SAMPLE_BITS (SAMPLE_BITS),
    .SUM_W       (SUM_W),
    .KEPT_W      (KEPT_W)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (accept),
    .sample_i    (sample_i),
    .cfg_count_i (count_q),
    .push_o      (f_push),
    .sum_o       (f_sum),
    .hi0_o       (f_hi0),
    .hi1_o       (f_hi1),
    .lo0_o       (f_lo0),
    .lo1_o       (f_lo1),
    .kept_o      (f_kept)
  );

  assign q_wdata = {f_sum, f_hi0, f_hi1, f_lo0, f_lo1, f_kept};
  assign {b_sum, b_hi0, b_hi1, b_lo0, b_lo1, b_kept} = q_rdata;

  tmf_queue #(
    .WIDTH (ENTRY_W),
    .DEPTH (tmf_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_rdata)
  );

  tmf_back #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .SUM_W       (SUM_W),
    .KEPT_W      (KEPT_W)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .sum_i     (b_sum),
    .hi0_i     (b_hi0),
    .hi1_i     (b_hi1),
    .lo0_i     (b_lo0),
    .lo1_i     (b_lo1),
    .kept_i    (b_kept),
    .q_pop_o   (q_pop),
    .pop_i     (pop),
    .empty_o   (empty),
    .mean_o    (trimmed_mean_o)
  );

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the trimmed mean filter.
// ----------------------------------------------------------------------------
// Samples are pushed into the filter. The testbench folds each accepted
// sample into its own copy of the set state: sum, two highest, two lowest,
// count. At the end of each set it queues the expected mean, and every popped
// result is compared against the oldest entry. A short table of directed
// samples and set-size writes comes first. Random sets follow under three
// idle profiles. One long reader stall makes the input side back up.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int CFG_W           = tmf_pkg::CFG_W;
  localparam int CFG_RESET       = tmf_pkg::CFG_RESET;
  localparam int MIN_SET         = tmf_pkg::MIN_SET;
  localparam int DROP_TOTAL      = tmf_pkg::DROP_TOTAL;
  localparam int DEF_MAX_SAMPLES = tmf_pkg::DEF_MAX_SAMPLES;

  localparam int SW            = tmf_pkg::DEF_SAMPLE_BITS;
  localparam int SUM_BITS      = SW + 5;
  localparam int DIV_CYCLES    = SUM_BITS + 3;
  localparam int SETTLE_CYCLES = 2 * DIV_CYCLES;
  localparam int RAND_ITEMS    = 1700;
  localparam int HOLD_CYCLES   = 300;
  localparam int STALL_LIMIT   = 4000;
  localparam int REPORT_MAX    = 10;

  typedef enum logic {ROW_CFG, ROW_SAMPLE} row_kind_e;

  typedef struct packed {
    row_kind_e     kind;
    logic [SW-1:0] value;
    logic          typed;
    logic [SW-1:0] mean;
  } stim_row_t;

  localparam int DIR_ROWS = 33;
  localparam stim_row_t DIRECTED [DIR_ROWS] = '{
    // reset set size of ten, both extremes twice each
    '{ROW_SAMPLE, 16'h0000, 1'b0, 16'h0000},
    '{ROW_SAMPLE, 16'hFFFF, 1'b0, 16'h0000},
    '{ROW_SAMPLE, 16'h0000, 1'b0, 16'h0000},
    '{ROW_SAMPLE, 16'hFFFF, 1'b0, 16'h0000},
    '{ROW_SAMPLE, 16'h0100, 1'b0, 16'h0000},
    '{ROW_SAMPLE, 16'h0100, 1'b0, 16'h0000},
    '{ROW_SAMPLE, 16'h0100, 1'b0, 16'h0000},
    '{ROW_SAMPLE, 16'h0100, 1'b0, 16'h0000},
    '{ROW_SAMPLE, 16'h0100, 1'b0, 16'h0000},
    '{ROW_SAMPLE, 16'h0100, 1'b1, 16'h0100},
    // count below the minimum acts as five
    '{ROW_CFG,    16'h0000, 1'b0, 16'h0000},
    '{ROW_SAMPLE, 16'hFFFF, 1'b0, 16'h0000},
    '{ROW_SAMPLE, 16'h8000, 1'b0, 16'h0000},
    '{ROW_SAMPLE, 16'h0001, 1'b0, 16'h0000},
    '{ROW_SAMPLE, 16'hFFFE, 1'b0, 16'h0000},
    '{ROW_SAMPLE, 16'h7FFF, 1'b0, 16'h0000},
    // count lowered mid-set, set ends on reaching the new size
    '{ROW_CFG,    16'h000C, 1'b0, 16'h0000},
    '{ROW_SAMPLE, 16'h0010, 1'b0, 16'h0000},
    '{ROW_SAMPLE, 16'hF000, 1'b0, 16'h0000},
    '{ROW_SAMPLE, 16'h0400, 1'b0, 16'h0000},
    '{ROW_CFG,    16'h0003, 1'b0, 16'h0000},
    '{ROW_SAMPLE, 16'h0300, 1'b0, 16'h0000},
    '{ROW_SAMPLE, 16'h0001, 1'b0, 16'h0000},
    // count lowered to the number of samples already seen
    '{ROW_CFG,    16'h0010, 1'b0, 16'h0000},
    '{ROW_SAMPLE, 16'h1234, 1'b0, 16'h0000},
    '{ROW_SAMPLE, 16'h5678, 1'b0, 16'h0000},
    '{ROW_SAMPLE, 16'h9ABC, 1'b0, 16'h0000},
    '{ROW_SAMPLE, 16'hDEF0, 1'b0, 16'h0000},
    '{ROW_SAMPLE, 16'h0FED, 1'b0, 16'h0000},
    '{ROW_CFG,    16'h0005, 1'b0, 16'h0000},
    '{ROW_SAMPLE, 16'h4321, 1'b0, 16'h0000},
    // upper clamp
    '{ROW_CFG,    16'h003F, 1'b0, 16'h0000},
    '{ROW_SAMPLE, 16'hA5A5, 1'b0, 16'h0000}
  };

  logic              clk_i          = 1'b0;
  logic              rst_ni         = 1'b0;
  logic              cfg_we_i       = 1'b0;
  logic [CFG_W-1:0]  cfg_wdata_i    = '0;
  logic              push           = 1'b0;
  logic              full;
  logic [SW-1:0]     sample_i       = '0;
  logic              empty;
  logic              pop            = 1'b0;
  logic [SW-1:0]     trimmed_mean_o;

  // mirror of the set state
  logic [CFG_W-1:0]    set_size_reg;
  logic [SUM_BITS-1:0] sum_acc;
  logic [SW-1:0]       hi_first, hi_second, lo_first, lo_second;
  int unsigned         seen;

  logic [SW-1:0] pending_means [$];
  int            mismatches     = 0;
  int            idle_cycles    = 0;
  int            send_idle_pct  = 0;
  int            recv_idle_pct  = 0;
  bit            hold_req       = 1'b0;

  trimmed_mean_filter i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .push          (push),
    .full          (full),
    .sample_i      (sample_i),
    .empty         (empty),
    .pop           (pop),
    .trimmed_mean_o(trimmed_mean_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic void clear_set();
    sum_acc   = '0;
    hi_first  = '0;
    hi_second = '0;
    lo_first  = '1;
    lo_second = '1;
    seen      = 0;
  endfunction

  // returns 1 when the sample closes a set
  function automatic bit fold_sample(input logic [SW-1:0] s, output logic [SW-1:0] mean);
    int unsigned         size_eff;
    logic [SUM_BITS-1:0] kept_sum;
    int unsigned         kept;
    sum_acc = sum_acc + SUM_BITS'(s);
    if (s > hi_first) begin
      hi_second = hi_first;
      hi_first  = s;
    end else if (s > hi_second) begin
      hi_second = s;
    end
    if (s < lo_first) begin
      lo_second = lo_first;
      lo_first  = s;
    end else if (s < lo_second) begin
      lo_second = s;
    end
    if (seen < 32'hFFFF) seen++;
    size_eff = set_size_reg;
    if (size_eff < MIN_SET) size_eff = MIN_SET;
    if (size_eff > DEF_MAX_SAMPLES) size_eff = DEF_MAX_SAMPLES;
    mean = '0;
    if (seen < size_eff) return 1'b0;
    kept_sum = sum_acc - SUM_BITS'(hi_first) - SUM_BITS'(hi_second)
               - SUM_BITS'(lo_first) - SUM_BITS'(lo_second);
    kept = seen - DROP_TOTAL;
    mean = SW'(kept_sum / kept);
    clear_set();
    return 1'b1;
  endfunction

  function automatic logic [SW-1:0] pick_sample();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      2:       return SW'($urandom_range(3) * 32'h4000);
      3:       return SW'(32'h0100 + $urandom_range(15));
      default: return SW'($urandom_range(32'hFFFF));
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_set_size();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2:       return CFG_W'(DEF_MAX_SAMPLES);
      3:       return CFG_W'(MIN_SET);
      4:       return CFG_W'($urandom_range(63));
      default: return CFG_W'($urandom_range(9, 5));
    endcase
  endfunction

  task automatic send_sample(input logic [SW-1:0] v, input logic use_typed,
                             input logic [SW-1:0] typed_mean);
    logic [SW-1:0] mean;
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push     <= 1'b1;
    sample_i <= v;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    if (fold_sample(v, mean)) pending_means.push_back(use_typed ? typed_mean : mean);
  endtask

  // drain all results, then let the back end finish before touching config
  task automatic drain_and_settle();
    push <= 1'b0;
    while (pending_means.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_set_size(input logic [CFG_W-1:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    set_size_reg = v;
  endtask

  // reader: random pop, long hold-off on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      pop <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      if (pending_means.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("unexpected mean %h at %0t", trimmed_mean_o, $realtime);
      end else begin
        if (trimmed_mean_o !== pending_means[0]) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("mean mismatch: expected %h, got %h at %0t",
                     pending_means[0], trimmed_mean_o, $realtime);
        end
        void'(pending_means.pop_front());
      end
    end
  end

  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    int  sent;
    int  n_items;
    bit  pressure_done;
    set_size_reg  = CFG_W'(CFG_RESET);
    clear_set();
    sent          = 0;
    pressure_done = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 29;
    recv_idle_pct = 58;
    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].kind == ROW_CFG) begin
        drain_and_settle();
        write_set_size(DIRECTED[i].value[CFG_W-1:0]);
      end else begin
        send_sample(DIRECTED[i].value, DIRECTED[i].typed, DIRECTED[i].mean);
      end
    end

    while (sent < RAND_ITEMS) begin
      if (sent < RAND_ITEMS / 3) begin
        send_idle_pct = 29;
        recv_idle_pct = 58;
      end else if (sent < 2 * RAND_ITEMS / 3) begin
        send_idle_pct = 58;
        recv_idle_pct = 29;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      drain_and_settle();
      n_items = $urandom_range(60, 10);
      if (!pressure_done && sent >= 2 * RAND_ITEMS / 3) begin
        // short sets against a stalled reader back up into the input
        write_set_size(CFG_W'(MIN_SET));
        hold_req      = 1'b1;
        n_items       = 80;
        pressure_done = 1'b1;
      end else begin
        write_set_size(pick_set_size());
      end
      repeat (n_items) begin
        send_sample(pick_sample(), 1'b0, '0);
        sent++;
      end
    end

    drain_and_settle();
    if (pending_means.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
